### src/bounded_array_list_engine_top_defines.svh
// Assertion macros for the checker file of the array list engine.
// No dependencies; take in with a plain include.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BALE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bale assertion failed");

// Next-cycle implication, disabled while reset is high
`define BALE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bale assertion failed");

`endif

### src/bale_pkg.sv
// Shared types and constants of the bounded array list engine.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package bale_pkg;

   // Widest element address the engine supports (capacity up to 1024)
   localparam int MAX_AW = 10;

   // Capacity limit register value after reset
   localparam logic [5:0] CAP_LIMIT_RESET = 6'd32;

   typedef enum logic [2:0] {
      OP_INSERT_AT     = 3'd0,
      OP_DELETE_AT     = 3'd1,
      OP_INSERT_SORTED = 3'd2,
      OP_LINEAR_SEARCH = 3'd3,
      OP_BINARY_SEARCH = 3'd4,
      OP_STATS         = 3'd5
   } bale_op_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_REJECT    = 2'd2
   } bale_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHUP,
      ST_SHDN,
      ST_LSRCH,
      ST_LSWAP,
      ST_BRD,
      ST_BCMP,
      ST_STATS,
      ST_FIN
   } bale_state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [5:0]         position;
      logic signed [31:0] operand_value;
   } bale_req_type;

   typedef struct packed {
      bale_status_type    status;
      logic [4:0]         found_position;
      logic signed [31:0] removed_value;
      logic signed [31:0] minimum;
      logic signed [31:0] maximum;
      logic signed [31:0] total;
      logic [5:0]         count;
   } bale_rsp_type;

   // One cycle of requests from the sequencer to the element memory
   typedef struct packed {
      logic              wr_en;
      logic [MAX_AW-1:0] wr_addr;
      logic [31:0]       wr_data;
      logic              rd_en;
      logic [MAX_AW-1:0] rd_addr;
   } bale_mem_req_type;

endpackage

### src/bounded_array_list_engine_top.sv
// Bounded array list engine: a packed list of signed 32-bit words with
// insert, delete, sorted insert, searches and statistics. One request beat
// gives one response beat; items are taken one at a time. Shifts, the
// linear search and the statistics walk step through the element store one
// entry per cycle through its single read port; the binary search reads one
// entry per halving step. A response held by rsp_stall keeps the engine busy.
// The store needs no clearing pass after reset: only entries below the count
// are ever read. The capacity limit register (reset 32) caps the count at
// its value as well as at CAPACITY; write it only while idle.
// Depends on bale_pkg, bale_ctrl and bale_mem.
`timescale 1ns / 1ps

module bounded_array_list_engine_top #(
   parameter int CAPACITY = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bale_pkg::bale_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bale_pkg::bale_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [5:0]             csr_wr_data
);

   logic [5:0]                 cap_limit_ff;
   logic [5:0]                 cap_limit_in;
   bale_pkg::bale_mem_req_type mem_req;
   logic [31:0]                mem_rdata;

   // capacity limit register
   assign cap_limit_in = csr_wr_en ? csr_wr_data : cap_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_limit_ff <= bale_pkg::CAP_LIMIT_RESET;
      end else begin
         cap_limit_ff <= cap_limit_in;
      end
   end

   bale_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cap_limit (cap_limit_ff),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   bale_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

endmodule

### src/bale_mem.sv
// Element store: one write port, one read port, registered read data.
// Depends on bale_pkg for the memory request struct.
`timescale 1ns / 1ps

module bale_mem #(
   parameter int DEPTH = 32
) (
   input  logic                      clock,
   input  bale_pkg::bale_mem_req_type mem_req,
   output logic [31:0]               rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0] ram_ff [DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ram_ff[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= ram_ff[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/bale_ctrl.sv
// Sequencer of the array list engine: decodes a request, walks the element
// store through bale_mem, and holds the result beat. Depends on bale_pkg.
`timescale 1ns / 1ps

module bale_ctrl #(
   parameter int CAPACITY = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bale_pkg::bale_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bale_pkg::bale_rsp_type     rsp_data,
   input  logic [5:0]                 cap_limit,
   output bale_pkg::bale_mem_req_type mem_req,
   input  logic [31:0]                mem_rdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

   bale_pkg::bale_state_type state_ff, state_in;

   logic [2:0]           op_ff, op_in;
   logic [31:0]          val_ff, val_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        paddr_ff, paddr_in;
   logic                 first_ff, first_in;
   logic                 srt_ff, srt_in;
   logic [31:0]          hold_ff, hold_in;
   logic [AW-1:0]        found_ff, found_in;
   logic [AW-1:0]        mid_ff, mid_in;
   logic signed [CW:0]   lo_ff, lo_in;
   logic signed [CW:0]   hi_ff, hi_in;
   logic [31:0]          mn_ff, mn_in;
   logic [31:0]          mx_ff, mx_in;
   logic [31:0]          sum_ff, sum_in;
   bale_pkg::bale_status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bale_pkg::bale_rsp_type rsp_data_ff, rsp_data_in;

   logic                 req_fire;
   logic [WW-1:0]        count_w;
   logic [WW-1:0]        pos_w;
   logic                 room;
   logic                 ins_ok;
   logic                 del_ok;
   logic                 nonempty;
   logic [CW-1:0]        rem_pos;
   logic [AW-1:0]        last_addr;
   logic                 walking;
   logic                 walk_end;
   logic                 hit;
   logic                 val_lt;
   logic [AW-1:0]        up_addr;
   logic [AW-1:0]        dn_addr;
   logic signed [CW+1:0] bsum;
   logic [AW-1:0]        bmid;
   logic                 bs_live;
   logic signed [CW:0]   mid_s;
   logic                 rsp_free;
   logic                 sel_found;

   // request decode and checks
   assign req_stall = reset || (state_ff != bale_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign count_w   = WW'(count_ff);
   assign pos_w     = WW'(req_data.position);
   assign room      = (count_w < WW'(cap_limit)) && (count_ff < CAP_W);
   assign ins_ok    = room && (pos_w <= count_w);
   assign del_ok    = pos_w < count_w;
   assign nonempty  = count_ff != '0;
   assign rem_pos   = CW'(count_w - pos_w);
   assign last_addr = AW'(count_ff - CW'(1));

   // walk status: a read was issued last cycle (pend) and reads still owed (rem)
   assign walking  = (state_ff == bale_pkg::ST_SHUP) || (state_ff == bale_pkg::ST_SHDN) ||
                     (state_ff == bale_pkg::ST_LSRCH) || (state_ff == bale_pkg::ST_STATS);
   assign walk_end = !pend_ff && (rem_ff == '0);
   assign hit      = mem_rdata == val_ff;
   assign val_lt   = $signed(val_ff) < $signed(mem_rdata);
   assign up_addr  = paddr_ff + AW'(1);
   assign dn_addr  = paddr_ff - AW'(1);

   // binary search midpoint; lo <= hi keeps the sum non-negative
   assign bsum    = (CW+2)'(lo_ff) + (CW+2)'(hi_ff);
   assign bmid    = bsum[AW:1];
   assign bs_live = lo_ff <= hi_ff;
   assign mid_s   = $signed((CW+1)'(mid_ff));

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign sel_found = (op_ff == bale_pkg::OP_LINEAR_SEARCH) ||
                      (op_ff == bale_pkg::OP_BINARY_SEARCH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bale_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  bale_pkg::OP_INSERT_AT:
                     state_in = ins_ok ? bale_pkg::ST_SHUP : bale_pkg::ST_FIN;
                  bale_pkg::OP_DELETE_AT:
                     state_in = del_ok ? bale_pkg::ST_SHDN : bale_pkg::ST_FIN;
                  bale_pkg::OP_INSERT_SORTED:
                     state_in = room ? bale_pkg::ST_SHUP : bale_pkg::ST_FIN;
                  bale_pkg::OP_LINEAR_SEARCH: state_in = bale_pkg::ST_LSRCH;
                  bale_pkg::OP_BINARY_SEARCH: state_in = bale_pkg::ST_BRD;
                  bale_pkg::OP_STATS:
                     state_in = nonempty ? bale_pkg::ST_STATS : bale_pkg::ST_FIN;
                  default: state_in = bale_pkg::ST_FIN;
               endcase
            end
         end
         bale_pkg::ST_SHUP: begin
            if ((pend_ff && srt_ff && !val_lt) || walk_end) begin
               state_in = bale_pkg::ST_FIN;
            end
         end
         bale_pkg::ST_SHDN: begin
            if (walk_end) state_in = bale_pkg::ST_FIN;
         end
         bale_pkg::ST_LSRCH: begin
            if (pend_ff && hit) begin
               state_in = bale_pkg::ST_LSWAP;
            end else if (walk_end) begin
               state_in = bale_pkg::ST_FIN;
            end
         end
         bale_pkg::ST_LSWAP: state_in = bale_pkg::ST_FIN;
         bale_pkg::ST_BRD: state_in = bs_live ? bale_pkg::ST_BCMP : bale_pkg::ST_FIN;
         bale_pkg::ST_BCMP: state_in = hit ? bale_pkg::ST_FIN : bale_pkg::ST_BRD;
         bale_pkg::ST_STATS: begin
            if (walk_end) state_in = bale_pkg::ST_FIN;
         end
         bale_pkg::ST_FIN: begin
            if (rsp_free) state_in = bale_pkg::ST_IDLE;
         end
         default: state_in = bale_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory requests
   // The walks never read an entry that was written in the same or the
   // previous cycle (shift writes trail the reads by two entries, the search
   // swap happens after the walk stops), so no forwarding is needed.
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      pend_in      = 1'b0;
      paddr_in     = paddr_ff;
      first_in     = first_ff;
      srt_in       = srt_ff;
      hold_in      = hold_ff;
      found_in     = found_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mn_in        = mn_ff;
      mx_in        = mx_ff;
      sum_in       = sum_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;

      // one read a cycle while a walk still owes reads
      if (walking && (rem_ff != '0)) begin
         mem_req.rd_en   = 1'b1;
         mem_req.rd_addr = bale_pkg::MAX_AW'(ptr_ff);
         paddr_in        = ptr_ff;
         pend_in         = 1'b1;
         rem_in          = rem_ff - CW'(1);
         ptr_in          = (state_ff == bale_pkg::ST_SHUP) ? ptr_ff - AW'(1)
                                                            : ptr_ff + AW'(1);
      end

      case (state_ff)
         bale_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_data.opcode;
               val_in   = req_data.operand_value;
               found_in = '0;
               hold_in  = '0;
               mn_in    = '0;
               mx_in    = '0;
               sum_in   = '0;
               first_in = 1'b1;
               srt_in   = 1'b0;
               lo_in    = '0;
               hi_in    = $signed({1'b0, count_ff}) - $signed((CW+1)'(1));
               ptr_in   = '0;
               rem_in   = count_ff;
               pos_in   = '0;
               case (req_data.opcode)
                  bale_pkg::OP_INSERT_AT: begin
                     ptr_in    = last_addr;
                     rem_in    = rem_pos;
                     pos_in    = AW'(req_data.position);
                     status_in = ins_ok ? bale_pkg::STAT_DONE : bale_pkg::STAT_REJECT;
                     if (ins_ok) count_in = count_ff + CW'(1);
                  end
                  bale_pkg::OP_DELETE_AT: begin
                     ptr_in    = AW'(req_data.position);
                     rem_in    = rem_pos;
                     status_in = del_ok ? bale_pkg::STAT_DONE : bale_pkg::STAT_REJECT;
                     if (del_ok) count_in = count_ff - CW'(1);
                  end
                  bale_pkg::OP_INSERT_SORTED: begin
                     ptr_in    = last_addr;
                     srt_in    = 1'b1;
                     status_in = room ? bale_pkg::STAT_DONE : bale_pkg::STAT_REJECT;
                     if (room) count_in = count_ff + CW'(1);
                  end
                  bale_pkg::OP_LINEAR_SEARCH: status_in = bale_pkg::STAT_NOT_FOUND;
                  bale_pkg::OP_BINARY_SEARCH: status_in = bale_pkg::STAT_NOT_FOUND;
                  bale_pkg::OP_STATS:
                     status_in = nonempty ? bale_pkg::STAT_DONE : bale_pkg::STAT_REJECT;
                  default: status_in = bale_pkg::STAT_REJECT;
               endcase
            end
         end

         // move entries up one place, then drop the new word into the gap
         bale_pkg::ST_SHUP: begin
            mem_req.wr_en = 1'b1;
            if (pend_ff && srt_ff && !val_lt) begin
               mem_req.wr_addr = bale_pkg::MAX_AW'(up_addr);
               mem_req.wr_data = val_ff;
            end else if (pend_ff) begin
               mem_req.wr_addr = bale_pkg::MAX_AW'(up_addr);
               mem_req.wr_data = mem_rdata;
            end else if (rem_ff == '0) begin
               mem_req.wr_addr = bale_pkg::MAX_AW'(pos_ff);
               mem_req.wr_data = val_ff;
            end else begin
               mem_req.wr_en = 1'b0;
            end
         end

         // first read is the removed word, the rest move down one place
         bale_pkg::ST_SHDN: begin
            if (pend_ff && first_ff) begin
               hold_in  = mem_rdata;
               first_in = 1'b0;
            end else if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = bale_pkg::MAX_AW'(dn_addr);
               mem_req.wr_data = mem_rdata;
            end
         end

         // scan from the front; keep the front word for the swap
         bale_pkg::ST_LSRCH: begin
            if (pend_ff) begin
               if (paddr_ff == '0) hold_in = mem_rdata;
               if (hit) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = '0;
                  mem_req.wr_data = val_ff;
                  found_in        = paddr_ff;
                  status_in       = bale_pkg::STAT_DONE;
               end
            end
         end

         bale_pkg::ST_LSWAP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = bale_pkg::MAX_AW'(found_ff);
            mem_req.wr_data = hold_ff;
         end

         bale_pkg::ST_BRD: begin
            if (bs_live) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = bale_pkg::MAX_AW'(bmid);
               mid_in          = bmid;
            end
         end

         bale_pkg::ST_BCMP: begin
            if (hit) begin
               found_in  = mid_ff;
               status_in = bale_pkg::STAT_DONE;
            end else if (val_lt) begin
               hi_in = mid_s - $signed((CW+1)'(1));
            end else begin
               lo_in = mid_s + $signed((CW+1)'(1));
            end
         end

         // running minimum, maximum and wrapping sum
         bale_pkg::ST_STATS: begin
            if (pend_ff && first_ff) begin
               mn_in    = mem_rdata;
               mx_in    = mem_rdata;
               sum_in   = mem_rdata;
               first_in = 1'b0;
            end else if (pend_ff) begin
               if ($signed(mem_rdata) < $signed(mn_ff)) mn_in = mem_rdata;
               if ($signed(mx_ff) < $signed(mem_rdata)) mx_in = mem_rdata;
               sum_in = sum_ff + mem_rdata;
            end
         end

         // hand the result to the output register once it is free
         bale_pkg::ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.found_position  = sel_found ? 5'(found_ff) : 5'd0;
               rsp_data_in.removed_value   = (op_ff == bale_pkg::OP_DELETE_AT) ? hold_ff
                                                                               : 32'd0;
               rsp_data_in.minimum         = mn_ff;
               rsp_data_in.maximum         = mx_ff;
               rsp_data_in.total           = sum_ff;
               rsp_data_in.count           = 6'(count_ff);
            end
         end

         default: begin
            mem_req = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bale_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      ptr_ff      <= ptr_in;
      rem_ff      <= rem_in;
      paddr_ff    <= paddr_in;
      first_ff    <= first_in;
      srt_ff      <= srt_in;
      hold_ff     <= hold_in;
      found_ff    <= found_in;
      mid_ff      <= mid_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      sum_ff      <= sum_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/bale_chk.sv
// Port-level checker for the array list engine, bound to the top level.
// Depends on bale_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "bounded_array_list_engine_top_defines.svh"

module bale_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input bale_pkg::bale_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bale_pkg::bale_rsp_type rsp_data
);

   logic req_fire;

   assign req_fire = req_valid && !req_stall && (req_data.opcode == req_data.opcode);

   // a stalled response beat holds
   `BALE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // one item at a time: busy right after taking a request
   `BALE_ASSERT_NEXT(a_busy_after_fire, clock, reset, req_fire, req_stall)

   // a rejected item reports no values
   `BALE_ASSERT_IMPL(a_reject_clean, clock, reset, rsp_valid && (rsp_data.status == bale_pkg::STAT_REJECT), (rsp_data.found_position == '0) && (rsp_data.removed_value == '0) && (rsp_data.minimum == '0) && (rsp_data.maximum == '0) && (rsp_data.total == '0))

   // a missed search reports no position, no removed value and no total
   `BALE_ASSERT_IMPL(a_miss_clean, clock, reset, rsp_valid && (rsp_data.status == bale_pkg::STAT_NOT_FOUND), (rsp_data.found_position == '0) && (rsp_data.removed_value == '0) && (rsp_data.total == '0))

endmodule

bind bounded_array_list_engine_top bale_chk u_bale_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### test/testbench.sv
// Self-checking testbench for the bounded array list engine top level.
// Depends on bale_pkg and bounded_array_list_engine_top; a scoreboard class
// predicts every response beat and compares it field by field.
`timescale 1ns / 1ps

module testbench;

   // Opcodes the engine does not define; it must reject them
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int LIST_DEPTH = 32;
   localparam int REPORT_LINES = 100;
   localparam int SEGMENT_ITEMS = 80;
   localparam int SETTLE_CYCLES = 50;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

   // List predictor plus queue of expected response beats
   class list_scoreboard;
      logic signed [31:0] words[LIST_DEPTH];
      int fill;
      int cap_limit;
      int mismatches;
      int rsp_index;
      bale_pkg::bale_rsp_type expected_q[$];

      function new();
         fill = 0;
         cap_limit = int'(bale_pkg::CAP_LIMIT_RESET);
         mismatches = 0;
         rsp_index = 0;
      endfunction

      function void set_capacity(int limit);
         cap_limit = limit;
      endfunction

      // Usable capacity: the register value clipped to the store depth
      function int room();
         return (cap_limit < LIST_DEPTH) ? cap_limit : LIST_DEPTH;
      endfunction

      function logic signed [31:0] any_element();
         return words[$urandom_range(fill - 1)];
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= REPORT_LINES)
            $display("ERROR at %0t, response %0d: %s", $time, rsp_index, msg);
      endtask

      // Apply one accepted request beat and queue the response it should give
      function void note_request(bale_pkg::bale_req_type item);
         bale_pkg::bale_rsp_type r;
         logic signed [31:0] key;
         logic signed [31:0] held;
         int n;
         int i;
         int lo;
         int hi;
         int mid;
         n = fill;
         key = item.operand_value;
         r = '0;
         r.status = bale_pkg::STAT_REJECT;
         case (item.opcode)
            bale_pkg::OP_INSERT_AT: begin
               if (n < room() && item.position <= n) begin
                  for (i = n; i > item.position; i--) words[i] = words[i - 1];
                  words[item.position] = key;
                  fill = n + 1;
                  r.status = bale_pkg::STAT_DONE;
               end
            end
            bale_pkg::OP_DELETE_AT: begin
               if (item.position < n) begin
                  r.removed_value = words[item.position];
                  for (i = item.position; i + 1 < n; i++) words[i] = words[i + 1];
                  fill = n - 1;
                  r.status = bale_pkg::STAT_DONE;
               end
            end
            bale_pkg::OP_INSERT_SORTED: begin
               // equal keys stay ahead of the new word
               if (n < room()) begin
                  i = n;
                  while (i > 0 && key < words[i - 1]) begin
                     words[i] = words[i - 1];
                     i--;
                  end
                  words[i] = key;
                  fill = n + 1;
                  r.status = bale_pkg::STAT_DONE;
               end
            end
            bale_pkg::OP_LINEAR_SEARCH: begin
               // first hit trades places with the front element
               r.status = bale_pkg::STAT_NOT_FOUND;
               for (i = 0; i < n; i++) begin
                  if (words[i] == key) begin
                     held = words[i];
                     words[i] = words[0];
                     words[0] = held;
                     r.found_position = 5'(i);
                     r.status = bale_pkg::STAT_DONE;
                     break;
                  end
               end
            end
            bale_pkg::OP_BINARY_SEARCH: begin
               // halving runs the same way whether or not the list is in order
               r.status = bale_pkg::STAT_NOT_FOUND;
               lo = 0;
               hi = n - 1;
               while (lo <= hi) begin
                  mid = (lo + hi) / 2;
                  if (words[mid] == key) begin
                     r.found_position = 5'(mid);
                     r.status = bale_pkg::STAT_DONE;
                     break;
                  end else if (key < words[mid]) begin
                     hi = mid - 1;
                  end else begin
                     lo = mid + 1;
                  end
               end
            end
            bale_pkg::OP_STATS: begin
               if (n > 0) begin
                  r.minimum = words[0];
                  r.maximum = words[0];
                  for (i = 0; i < n; i++) begin
                     if (words[i] < r.minimum) r.minimum = words[i];
                     if (words[i] > r.maximum) r.maximum = words[i];
                     r.total = r.total + words[i];
                  end
                  r.status = bale_pkg::STAT_DONE;
               end
            end
            default: ;
         endcase
         r.count = 6'(fill);
         expected_q.push_back(r);
      endfunction

      task compare_field(string field, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s is %h, expected %h", field, got, want));
      endtask

      task check_response(bale_pkg::bale_rsp_type got);
         bale_pkg::bale_rsp_type want;
         if (expected_q.size() == 0) begin
            report("response beat with nothing expected");
         end else begin
            want = expected_q.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("found_position", 32'(got.found_position),
                          32'(want.found_position));
            compare_field("removed_value", got.removed_value, want.removed_value);
            compare_field("minimum", got.minimum, want.minimum);
            compare_field("maximum", got.maximum, want.maximum);
            compare_field("total", got.total, want.total);
            compare_field("count", 32'(got.count), 32'(want.count));
         end
         rsp_index++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   bale_pkg::bale_req_type req_data;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bale_pkg::bale_rsp_type rsp_data;
   logic csr_wr_en;
   logic [5:0] csr_wr_data;

   list_scoreboard sb = new();

   int send_idle_pct = 37;
   int recv_stall_pct = 75;
   bit sorted_mode = 1'b1;
   bit grow = 1'b1;
   int seg_left = 0;

   int phase_cap[9] = '{32, 1, 5, 63, 0, 12, 32, 2, 32};
   int phase_len[9] = '{130, 60, 100, 130, 20, 100, 130, 60, 120};

   bounded_array_list_engine_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Beat monitor: request first so a prediction is always queued in time
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   // Drive one request beat; returns at the falling edge after acceptance
   task automatic send_item(input bale_pkg::bale_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue(input logic [2:0] op, input logic [5:0] pos,
                        input logic [31:0] val);
      bale_pkg::bale_req_type item;
      item.opcode = op;
      item.position = pos;
      item.operand_value = val;
      send_item(item);
   endtask

   // Let all expected responses come back before touching the register
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input int limit);
      csr_wr_en = 1'b1;
      csr_wr_data = 6'(limit);
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_capacity(limit);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2, 3, 4: return int'($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // Random request; grow steers inserts against deletes
   function automatic bale_pkg::bale_req_type make_item();
      bale_pkg::bale_req_type item;
      int k;
      logic [2:0] op;
      k = $urandom_range(19);
      if (sorted_mode) begin
         if (k < 9) op = grow ? bale_pkg::OP_INSERT_SORTED : bale_pkg::OP_DELETE_AT;
         else if (k < 10) op = bale_pkg::OP_INSERT_SORTED;
         else if (k < 11) op = bale_pkg::OP_DELETE_AT;
         else if (k < 18) op = bale_pkg::OP_BINARY_SEARCH;
         else op = bale_pkg::OP_STATS;
      end else begin
         if (k < 9)
            op = grow ? ((k < 5) ? bale_pkg::OP_INSERT_AT : bale_pkg::OP_INSERT_SORTED)
                      : bale_pkg::OP_DELETE_AT;
         else if (k < 10) op = bale_pkg::OP_INSERT_AT;
         else if (k < 11) op = bale_pkg::OP_DELETE_AT;
         else if (k < 14) op = bale_pkg::OP_LINEAR_SEARCH;
         else if (k < 17) op = bale_pkg::OP_BINARY_SEARCH;
         else if (k < 19) op = bale_pkg::OP_STATS;
         else op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
      end
      item.opcode = op;
      item.position = 6'($urandom_range(63));
      if (op == bale_pkg::OP_INSERT_AT && $urandom_range(99) < 85)
         item.position = 6'($urandom_range(sb.fill));
      if (op == bale_pkg::OP_DELETE_AT && sb.fill > 0 && $urandom_range(99) < 85)
         item.position = 6'($urandom_range(sb.fill - 1));
      item.operand_value = pick_value();
      if ((op == bale_pkg::OP_LINEAR_SEARCH || op == bale_pkg::OP_BINARY_SEARCH)
          && sb.fill > 0 && $urandom_range(99) < 60)
         item.operand_value = sb.any_element();
      return item;
   endfunction

   task automatic run_random(input int n_items);
      for (int j = 0; j < n_items; j++) begin
         if (seg_left == 0) begin
            seg_left = SEGMENT_ITEMS;
            sorted_mode = !sorted_mode;
            // sorted stretch starts empty so binary search sees an ordered list
            if (sorted_mode)
               while (sb.fill > 0)
                  issue(bale_pkg::OP_DELETE_AT, 6'($urandom_range(sb.fill - 1)), $urandom);
         end
         seg_left--;
         if (sb.fill == 0) grow = 1'b1;
         else if (sb.fill >= sb.room() && $urandom_range(3) == 0) grow = 1'b0;
         else if ($urandom_range(59) == 0) grow = !grow;
         send_item(make_item());
      end
   endtask

   // Stimulus and end of run
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list corners and undefined opcodes
      issue(bale_pkg::OP_STATS, 0, 0);
      issue(bale_pkg::OP_LINEAR_SEARCH, 0, 5);
      issue(bale_pkg::OP_BINARY_SEARCH, 0, 5);
      issue(bale_pkg::OP_DELETE_AT, 0, 0);
      issue(bale_pkg::OP_INSERT_AT, 1, 7);
      issue(OP_SPARE_6, 63, 32'hffffffff);
      // word extremes, insert in the middle and at the tail
      issue(bale_pkg::OP_INSERT_AT, 0, WORD_MAX);
      issue(bale_pkg::OP_INSERT_AT, 1, WORD_MIN);
      issue(bale_pkg::OP_INSERT_AT, 1, -1);
      issue(bale_pkg::OP_INSERT_AT, 3, WORD_MAX);
      issue(bale_pkg::OP_INSERT_AT, 63, 1);
      issue(bale_pkg::OP_STATS, 0, 0);
      // hit swaps to the front; miss
      issue(bale_pkg::OP_LINEAR_SEARCH, 0, WORD_MIN);
      issue(bale_pkg::OP_LINEAR_SEARCH, 0, 42);
      // bad delete positions, then a good one
      issue(bale_pkg::OP_DELETE_AT, 4, 0);
      issue(bale_pkg::OP_DELETE_AT, 63, 0);
      issue(bale_pkg::OP_DELETE_AT, 1, 0);
      issue(bale_pkg::OP_BINARY_SEARCH, 0, WORD_MAX);
      // equal keys land after existing ones
      issue(bale_pkg::OP_INSERT_SORTED, 0, 5);
      issue(bale_pkg::OP_INSERT_SORTED, 0, 5);
      issue(bale_pkg::OP_BINARY_SEARCH, 0, 6);
      issue(bale_pkg::OP_LINEAR_SEARCH, 0, WORD_MAX);
      issue(OP_SPARE_7, 0, 0);
      issue(bale_pkg::OP_BINARY_SEARCH, 0, WORD_MIN);
      issue(bale_pkg::OP_DELETE_AT, 0, 0);

      // random phases, each setting a capacity limit and an idle pattern
      for (int p = 0; p < 9; p++) begin
         wait_drained();
         if (p < 3) begin
            send_idle_pct = 37;
            recv_stall_pct = 75;
         end else if (p < 6) begin
            send_idle_pct = 75;
            recv_stall_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_capacity(phase_cap[p]);
         run_random(phase_len[p]);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/bale_pkg.sv
src/bale_mem.sv
src/bale_ctrl.sv
src/bounded_array_list_engine_top.sv
src/bale_chk.sv
test/testbench.sv
